@@ rtl/fifo_fair_reader_writer_lock_defines.svh @@
// Assertion macros for the reader-writer lock
`ifndef FIFO_FAIR_READER_WRITER_LOCK_DEFINES_SVH
`define FIFO_FAIR_READER_WRITER_LOCK_DEFINES_SVH
`ifndef SYNTHESIS
`define FFRW_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lock invariant violated");
`define FFRW_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lock implication violated");
`else
`define FFRW_ASSERT_ALWAYS(lbl, expr)
`define FFRW_ASSERT_IMPLIES(lbl, ante, cons)
`endif
`endif

@@ rtl/ffrw_pkg.sv @@
// Types, codes and helpers shared by the reader-writer lock
`timescale 1ns / 1ps
`default_nettype none
package ffrw_pkg;
	localparam int REQ_W = 4;
	localparam int CNT_W = 5;
	localparam int EV_W = 3;
	localparam logic [CNT_W-1:0] READER_MAX = 5'd31;
	localparam int MAX_GRANTS = 16;

	localparam logic [EV_W-1:0] EV_GRANTED = 3'd0;
	localparam logic [EV_W-1:0] EV_QUEUED = 3'd1;
	localparam logic [EV_W-1:0] EV_REFUSED = 3'd2;
	localparam logic [EV_W-1:0] EV_RELEASED = 3'd3;
	localparam logic [EV_W-1:0] EV_CANCELLED = 3'd4;
	localparam logic [EV_W-1:0] EV_ERROR = 3'd5;

	localparam logic [2:0] MODE_RBEGIN = 3'd0;
	localparam logic [2:0] MODE_WBEGIN = 3'd1;
	localparam logic [2:0] MODE_REND = 3'd2;
	localparam logic [2:0] MODE_WEND = 3'd3;
	localparam logic [2:0] MODE_CANCEL = 3'd4;

	typedef enum logic [2:0] {
		K_RBEGIN,
		K_WBEGIN,
		K_REND,
		K_WEND,
		K_CANCEL,
		K_BAD
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [REQ_W-1:0] req;
		logic nw;
	} item_t;

	typedef enum logic {
		ST_IDLE,
		ST_ADMIT
	} state_t;

	function automatic logic grantable(input logic rd, input logic [CNT_W-1:0] rc,
		input logic wr);
		grantable = rd ? (!wr && rc < READER_MAX) : (!wr && rc == '0);
	endfunction
endpackage
`default_nettype wire

@@ rtl/ffrw_front.sv @@
// Front end: classifies request beats and buffers them in a two-slot queue
`timescale 1ns / 1ps
`default_nettype none
module ffrw_front #(
	parameter int REQUESTERS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [2:0] mode,
	input wire logic [ffrw_pkg::REQ_W-1:0] requester,
	input wire logic no_wait,
	output ffrw_pkg::item_t item,
	output logic item_valid,
	input wire logic item_pop
);
	ffrw_pkg::item_t slot_q [2];
	ffrw_pkg::item_t cls;
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	always_comb begin
		cls.req = requester;
		cls.nw = no_wait;
		if (32'(requester) >= 32'(REQUESTERS)) begin
			cls.kind = ffrw_pkg::K_BAD;
		end else begin
			unique case (mode)
				ffrw_pkg::MODE_RBEGIN: cls.kind = ffrw_pkg::K_RBEGIN;
				ffrw_pkg::MODE_WBEGIN: cls.kind = ffrw_pkg::K_WBEGIN;
				ffrw_pkg::MODE_REND: cls.kind = ffrw_pkg::K_REND;
				ffrw_pkg::MODE_WEND: cls.kind = ffrw_pkg::K_WEND;
				ffrw_pkg::MODE_CANCEL: cls.kind = ffrw_pkg::K_CANCEL;
				default: cls.kind = ffrw_pkg::K_BAD;
			endcase
		end
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push = req_valid && !req_stall;
	assign item_valid = (cnt_q != 2'd0);
	assign pop = item_pop && item_valid;
	assign item = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= cls;
	end
endmodule
`default_nettype wire

@@ rtl/ffrw_engine.sv @@
// Back end: lock state, FIFO wait queue, admission sequencer and result register
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_fair_reader_writer_lock_defines.svh"
module ffrw_engine #(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire ffrw_pkg::item_t item,
	input wire logic item_valid,
	output logic item_pop,
	output logic res_valid,
	input wire logic res_stall,
	output logic [ffrw_pkg::REQ_W-1:0] agent,
	output logic [ffrw_pkg::EV_W-1:0] event_res,
	output logic reader_grant,
	output logic last,
	output logic [ffrw_pkg::CNT_W-1:0] readers_active,
	output logic writer_active,
	output logic [ffrw_pkg::CNT_W-1:0] waiting_count
);
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int LW = QW + 1;

	logic [ffrw_pkg::REQ_W-1:0] qid_q [QUEUE_DEPTH];
	logic qrd_q [QUEUE_DEPTH];
	logic [LW-1:0] len_q, len_n;
	logic [ffrw_pkg::CNT_W-1:0] rc_q, rc_n;
	logic wr_q, wr_n;
	ffrw_pkg::state_t state_q, st_n;
	logic [3:0] gcnt_q, gcnt_n;

	logic [QUEUE_DEPTH-1:0] match, sh, shmask;
	logic found, full, freeslot, push, ld, rd, cont, nxt, hd_rd, acc;
	logic [ffrw_pkg::REQ_W-1:0] o_agent;
	logic [ffrw_pkg::EV_W-1:0] o_ev;
	logic o_rg, o_last;

	always_comb begin
		acc = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match[i] = (LW'(i) < len_q) && (qid_q[i] == item.req);
			acc = acc | match[i];
			sh[i] = acc;
		end
	end

	assign found = |match;
	assign full = (len_q == LW'(QUEUE_DEPTH));
	assign freeslot = !res_valid || !res_stall;

	always_comb begin
		rc_n = rc_q;
		wr_n = wr_q;
		len_n = len_q;
		push = 1'b0;
		shmask = '0;
		ld = 1'b0;
		item_pop = 1'b0;
		o_agent = item.req;
		o_ev = ffrw_pkg::EV_ERROR;
		o_rg = 1'b0;
		o_last = 1'b1;
		st_n = state_q;
		gcnt_n = gcnt_q;
		rd = (item.kind == ffrw_pkg::K_RBEGIN);
		cont = 1'b0;
		nxt = 1'b0;
		hd_rd = 1'b0;
		unique case (state_q)
			ffrw_pkg::ST_IDLE: begin
				if (item_valid && freeslot) begin
					item_pop = 1'b1;
					ld = 1'b1;
					gcnt_n = '0;
					unique case (item.kind)
						ffrw_pkg::K_RBEGIN, ffrw_pkg::K_WBEGIN: begin
							if (found) begin
								o_ev = ffrw_pkg::EV_ERROR;
							end else if (len_q == '0 && ffrw_pkg::grantable(rd, rc_q, wr_q)) begin
								if (rd) rc_n = rc_q + 1'b1;
								else wr_n = 1'b1;
								o_ev = ffrw_pkg::EV_GRANTED;
								o_rg = rd;
							end else if (item.nw || full) begin
								o_ev = ffrw_pkg::EV_REFUSED;
							end else begin
								push = 1'b1;
								len_n = len_q + 1'b1;
								o_ev = ffrw_pkg::EV_QUEUED;
							end
						end
						ffrw_pkg::K_REND: begin
							if (!(wr_q || rc_q == '0)) begin
								rc_n = rc_q - 1'b1;
								o_ev = ffrw_pkg::EV_RELEASED;
								cont = 1'b1;
							end
						end
						ffrw_pkg::K_WEND: begin
							if (wr_q) begin
								wr_n = 1'b0;
								o_ev = ffrw_pkg::EV_RELEASED;
								cont = 1'b1;
							end
						end
						ffrw_pkg::K_CANCEL: begin
							if (found) begin
								shmask = sh;
								len_n = len_q - 1'b1;
								o_ev = ffrw_pkg::EV_CANCELLED;
								cont = 1'b1;
							end
						end
						default: o_ev = ffrw_pkg::EV_ERROR;
					endcase
					if (cont) begin
						hd_rd = (item.kind == ffrw_pkg::K_CANCEL && match[0]) ? qrd_q[1] : qrd_q[0];
						nxt = (len_n != '0) && ffrw_pkg::grantable(hd_rd, rc_n, wr_n);
						o_last = !nxt;
						if (nxt) st_n = ffrw_pkg::ST_ADMIT;
					end
				end
			end
			ffrw_pkg::ST_ADMIT: begin
				if (freeslot) begin
					ld = 1'b1;
					o_agent = qid_q[0];
					o_ev = ffrw_pkg::EV_GRANTED;
					o_rg = qrd_q[0];
					shmask = '1;
					len_n = len_q - 1'b1;
					if (qrd_q[0]) rc_n = rc_q + 1'b1;
					else wr_n = 1'b1;
					nxt = qrd_q[0] && (len_q > LW'(1)) && qrd_q[1]
						&& (rc_q < ffrw_pkg::READER_MAX - 1'b1)
						&& (gcnt_q != 4'(ffrw_pkg::MAX_GRANTS - 1));
					gcnt_n = gcnt_q + 1'b1;
					o_last = !nxt;
					if (!nxt) st_n = ffrw_pkg::ST_IDLE;
				end
			end
			default: st_n = ffrw_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffrw_pkg::ST_IDLE;
			rc_q <= '0;
			wr_q <= 1'b0;
			len_q <= '0;
			gcnt_q <= '0;
			res_valid <= 1'b0;
		end else begin
			state_q <= st_n;
			rc_q <= rc_n;
			wr_q <= wr_n;
			len_q <= len_n;
			gcnt_q <= gcnt_n;
			if (ld) res_valid <= 1'b1;
			else if (!res_stall) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			agent <= o_agent;
			event_res <= o_ev;
			reader_grant <= o_rg;
			last <= o_last;
			readers_active <= rc_n;
			writer_active <= wr_n;
			waiting_count <= ffrw_pkg::CNT_W'(len_n);
		end
	end

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
		if (g < QUEUE_DEPTH - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (shmask[g]) begin
					qid_q[g] <= qid_q[g+1];
					qrd_q[g] <= qrd_q[g+1];
				end else if (push && len_q == LW'(g)) begin
					qid_q[g] <= item.req;
					qrd_q[g] <= rd;
				end
			end
		end else begin : g_end
			always_ff @(posedge clk) begin
				if (!shmask[g] && push && len_q == LW'(g)) begin
					qid_q[g] <= item.req;
					qrd_q[g] <= rd;
				end
			end
		end
	end

	`FFRW_ASSERT_ALWAYS(a_excl, !(wr_q && rc_q != '0))
	`FFRW_ASSERT_ALWAYS(a_len, len_q <= LW'(QUEUE_DEPTH))
	`FFRW_ASSERT_IMPLIES(a_admit, state_q == ffrw_pkg::ST_ADMIT, len_q != '0)
endmodule
`default_nettype wire

@@ rtl/fifo_fair_reader_writer_lock.sv @@
// Top level of the FIFO-fair reader-writer lock
`timescale 1ns / 1ps
`default_nettype none
// Each request beat gives results at one beat per cycle, unless res_stall
// holds them: a begin, an end or a cancel gives one result, and a release or
// cancel is followed by up to 16 grant beats at the result register. A
// two-slot queue in front takes requests while results wait.
module fifo_fair_reader_writer_lock #(
	parameter int REQUESTERS = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire logic [2:0] mode,
	input wire logic [3:0] requester,
	input wire logic no_wait,
	output logic res_valid,
	input wire logic res_stall,
	output logic [3:0] agent,
	output logic [2:0] event_res,
	output logic reader_grant,
	output logic last,
	output logic [4:0] readers_active,
	output logic writer_active,
	output logic [4:0] waiting_count
);
	ffrw_pkg::item_t item;
	logic item_valid, item_pop;

	ffrw_front #(.REQUESTERS(REQUESTERS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.mode(mode), .requester(requester), .no_wait(no_wait),
		.item(item), .item_valid(item_valid), .item_pop(item_pop)
	);

	ffrw_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.item(item), .item_valid(item_valid), .item_pop(item_pop),
		.res_valid(res_valid), .res_stall(res_stall),
		.agent(agent), .event_res(event_res), .reader_grant(reader_grant),
		.last(last), .readers_active(readers_active),
		.writer_active(writer_active), .waiting_count(waiting_count)
	);
endmodule
`default_nettype wire
